FILE: design/hmbe_pkg.sv
`timescale 1ns / 1ps

package hmbe_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_BLOCK_SIZE = 2'd0;
    localparam logic [1:0] REG_KEY_LOW    = 2'd1;
    localparam logic [1:0] REG_KEY_HIGH   = 2'd2;

    localparam int MAX_N      = 4;
    localparam int BYTE_W     = 8;
    localparam int VALUE_W    = 18;
    localparam int KEY_W      = 128;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] N_MIN = 3'd2;
    localparam logic [2:0] N_MAX = 3'd4;

    // one full block on its way from the front to the back
    typedef struct packed {
        logic [MAX_N-1:0][BYTE_W-1:0] msg;
        logic [2:0]                   n;
    } t_block;

    // push side of the block queue
    typedef struct packed {
        logic   valid;
        t_block blk;
    } t_push;

    // clamp the block size register to the supported range
    function automatic logic [2:0] eff_n(input logic [2:0] size);
        logic [2:0] r;
        r = size;
        if (size < N_MIN) r = N_MIN;
        if (size > N_MAX) r = N_MAX;
        return r;
    endfunction

endpackage

FILE: design/hmbe_front.sv
`timescale 1ns / 1ps

module hmbe_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [2:0]                   i_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [hmbe_pkg::BYTE_W-1:0]  i_s_tdata,
    input  logic                         i_s_tlast,
    input  logic                         i_queue_full,
    output hmbe_pkg::t_push              o_push
);

    logic [1:0]                        r_fill;
    logic [1:0]                        n_fill;
    logic [2:0][hmbe_pkg::BYTE_W-1:0]  r_bb;
    logic                              w_complete;
    logic                              w_accept;
    logic [2:0]                        w_last_pos;

    // a block completes when this byte brings the fill up to n
    assign w_complete = ({1'b0, r_fill} + 3'd1) >= i_n;
    assign o_s_tready = !(w_complete && i_queue_full);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_last_pos = i_n - 3'd1;

    // assemble the block: stored bytes then the current byte, zeros beyond n
    always_comb begin
        o_push.valid = w_accept && w_complete;
        o_push.blk.n = i_n;
        for (int i = 0; i < hmbe_pkg::MAX_N; i++) begin
            if (3'(i) < w_last_pos && i < 3) begin
                o_push.blk.msg[i] = r_bb[i[1:0]];
            end else if (3'(i) == w_last_pos) begin
                o_push.blk.msg[i] = i_s_tdata;
            end else begin
                o_push.blk.msg[i] = '0;
            end
        end
    end

    // fill count next value
    always_comb begin
        n_fill = r_fill;
        if (w_accept) begin
            if (w_complete) begin
                n_fill = 2'd0;
            end else begin
                n_fill = r_fill + 2'd1;
            end
            if (i_s_tlast) begin
                n_fill = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 2'd0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // partial block storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bb <= '0;
        end else if (w_accept && !w_complete) begin
            r_bb[r_fill] <= i_s_tdata;
        end
    end

endmodule

FILE: design/hmbe_queue.sv
`timescale 1ns / 1ps

module hmbe_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hmbe_pkg::t_push  i_push,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output hmbe_pkg::t_block o_head
);

    hmbe_pkg::t_block [hmbe_pkg::QUEUE_DEPTH-1:0] r_mem;
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'(hmbe_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_mem[r_rd_ptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push.valid && !(i_pop && !o_empty)) begin
            n_count = r_count + 2'd1;
        end else if (!i_push.valid && i_pop && !o_empty) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push.valid) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop && !o_empty) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    // block storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.blk;
        end
    end

endmodule

FILE: design/hmbe_back.sv
`timescale 1ns / 1ps

module hmbe_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [hmbe_pkg::KEY_W-1:0]    i_key,
    input  logic                          i_empty,
    input  hmbe_pkg::t_block              i_head,
    output logic                          o_pop,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [hmbe_pkg::VALUE_W-1:0]  o_value,
    output logic                          o_m_tlast
);

    logic [1:0]                     r_col;
    logic                           r_out_valid;
    logic [hmbe_pkg::VALUE_W-1:0]   r_out_value;
    logic                           r_out_last;
    logic                           w_load;
    logic                           w_last_col;
    logic [hmbe_pkg::VALUE_W-1:0]   w_dot;
    logic [3:0]                     w_k;
    logic [hmbe_pkg::BYTE_W-1:0]    w_kb;

    assign w_load     = !i_empty && (!r_out_valid || i_m_tready);
    assign w_last_col = ({1'b0, r_col} == (i_head.n - 3'd1));
    assign o_pop      = w_load && w_last_col;

    // dot product of the block with key column r_col
    always_comb begin
        w_dot = '0;
        w_k   = '0;
        w_kb  = '0;
        for (int i = 0; i < hmbe_pkg::MAX_N; i++) begin
            w_k   = 4'(i * i_head.n) + {2'b00, r_col};
            w_kb  = i_key[{w_k, 3'b000} +: hmbe_pkg::BYTE_W];
            w_dot = w_dot + hmbe_pkg::VALUE_W'(i_head.msg[i] * w_kb);
        end
    end

    // column counter walks 0..n-1 over the head block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_col <= w_last_col ? 2'd0 : r_col + 2'd1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_value <= w_dot;
            r_out_last  <= w_last_col;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_value    = r_out_value;
    assign o_m_tlast  = r_out_last;

endmodule

FILE: design/hill_matrix_block_encrypt_unit.sv
`timescale 1ns / 1ps
// path: a completing byte's block is written into the queue, then the back end registers
// its first result; then one result a cycle unless i_m_tready stalls, until all n results of the block are out
// throughput: one byte a cycle while o_s_tready is high; the back end emits one result a
// cycle unless stalled, set by the single dot-product unit walking the head block's key columns
// reset: synchronous active low; clears fill count, queue, output valid and keys; block size to 2

module hill_matrix_block_encrypt_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] message_byte
    input  logic        i_s_tlast,   // end_of_message
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [17:0] cipher_value, [23:18] zero
    output logic        o_m_tlast    // last_of_block
);

    logic [2:0]                     r_block_size;
    logic [63:0]                    r_key_low;
    logic [63:0]                    r_key_high;
    logic [2:0]                     w_n;
    hmbe_pkg::t_push                w_push;
    hmbe_pkg::t_block               w_head;
    logic                           w_full;
    logic                           w_empty;
    logic                           w_pop;
    logic [hmbe_pkg::VALUE_W-1:0]   w_value;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= 3'd2;
            r_key_low    <= '0;
            r_key_high   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                hmbe_pkg::REG_BLOCK_SIZE: r_block_size <= i_cfg_data[2:0];
                hmbe_pkg::REG_KEY_LOW:    r_key_low    <= i_cfg_data;
                hmbe_pkg::REG_KEY_HIGH:   r_key_high   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_n = hmbe_pkg::eff_n(r_block_size);

    // front: gathers bytes into blocks
    hmbe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_n          (w_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_queue_full (w_full),
        .o_push       (w_push)
    );

    // short block queue between front and back
    hmbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    // back: one key column per cycle while a block waits and the output is not stalled
    hmbe_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key      ({r_key_high, r_key_low}),
        .i_empty    (w_empty),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_value    (w_value),
        .o_m_tlast  (o_m_tlast)
    );

    assign o_m_tdata = {6'b000000, w_value};

    // no block is pushed into a full queue unless that queue is popped in the same cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push.valid && w_full && !w_pop))
        else $error("block pushed into full queue");

    // the queue is only popped when it holds a block
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("pop from empty queue");

    // the output is empty right after reset
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // a loaded block's final result carries the last mark
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (o_m_tvalid && o_m_tlast))
        else $error("block end without last mark");

endmodule
